>>> rtl/core/rv64_pkg.sv
// Package: shared types, opcode constants and a sign-extension helper for the RV64I execute unit.
package rv64_pkg;

    localparam logic [63:0] START_ADDRESS = 64'd2147483648;
    localparam logic [63:0] MEMORY_BYTES  = 64'd134217728;
    localparam logic [63:0] STACK_TOP     = START_ADDRESS + MEMORY_BYTES - 64'd1;

    localparam int REG_COUNT = 32;

    localparam logic [6:0] OPC_LOAD    = 7'b0000011;
    localparam logic [6:0] OPC_OPIMM   = 7'b0010011;
    localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
    localparam logic [6:0] OPC_OPIMM32 = 7'b0011011;
    localparam logic [6:0] OPC_STORE   = 7'b0100011;
    localparam logic [6:0] OPC_OP      = 7'b0110011;
    localparam logic [6:0] OPC_LUI     = 7'b0110111;
    localparam logic [6:0] OPC_OP32    = 7'b0111011;
    localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
    localparam logic [6:0] OPC_JALR    = 7'b1100111;
    localparam logic [6:0] OPC_JAL     = 7'b1101111;
    localparam logic [6:0] F7_ZERO     = 7'b0000000;
    localparam logic [6:0] F7_ALT      = 7'b0100000;

    localparam logic [0:0] OP_EXEC  = 1'b0;
    localparam logic [0:0] OP_REPLY = 1'b1;

    localparam logic [2:0] KIND_RETIRED = 3'd0;
    localparam logic [2:0] KIND_LOAD    = 3'd1;
    localparam logic [2:0] KIND_STORE   = 3'd2;
    localparam logic [2:0] KIND_ILLEGAL = 3'd3;
    localparam logic [2:0] KIND_UNEXP   = 3'd4;

    localparam logic [2:0] LT_LB  = 3'd0;
    localparam logic [2:0] LT_LH  = 3'd1;
    localparam logic [2:0] LT_LW  = 3'd2;
    localparam logic [2:0] LT_LBU = 3'd4;
    localparam logic [2:0] LT_LHU = 3'd5;
    localparam logic [2:0] LT_LWU = 3'd6;

    typedef struct packed {
        logic [0:0]  op;
        logic [31:0] instr;
        logic [63:0] load_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] next_pc;
        logic [63:0] mem_addr;
        logic [1:0]  mem_size_log2;
        logic [63:0] store_data;
        logic [0:0]  reg_write;
        logic [4:0]  reg_index;
        logic [63:0] reg_value;
    } t_out_item;

    // register file write-back port
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [63:0] data;
    } t_rf_wr;

    function automatic logic [63:0] sext32(input logic [31:0] v);
        sext32 = {{32{v[31]}}, v};
    endfunction

endpackage

>>> rtl/core/rv64_if.sv
// Interfaces: valid/ready channels for the input and result transactions.
interface rv64_in_if;
    logic                 valid;
    logic                 ready;
    rv64_pkg::t_in_item   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rv64_out_if;
    logic                 valid;
    logic                 ready;
    rv64_pkg::t_out_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/rv64i_execute_unit.sv
// Top level: RV64I execute unit with RAM register file and one-entry result register.
//
// One instruction (op 0) or load reply (op 1) is a transaction on i_in; each
// gives exactly one result transaction on o_out. While o_out does not stall,
// the block sustains one transaction per cycle: an accepted item's register
// operands are read from the register file RAMs in the accept cycle, the
// item is executed in the next cycle against the forwarded RAM outputs, and
// the result is written back to the RAM and loaded into the output register
// in that same edge. A result waiting on a stalled o_out holds the execute
// stage; a new item is accepted whenever the execute stage is empty or will
// move on this cycle. Register x2 reads the stack top and the other
// registers zero after reset, through per-entry valid bits, so no clearing
// pass is needed. pc and the pending-load record live in flip-flops.
module rv64i_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rv64_in_if.sink     i_in,
    rv64_out_if.source  o_out
);
    logic                 r_ex_valid;
    rv64_pkg::t_in_item   r_ex_item;
    logic                 r_out_valid;
    rv64_pkg::t_out_item  r_out;
    logic [63:0]          r_pc;
    logic                 r_ld_pend;
    logic [4:0]           r_ld_dest;
    logic [2:0]           r_ld_type;

    logic                 w_ex_go;
    logic                 w_accept;
    logic [63:0]          w_a;
    logic [63:0]          w_b;
    rv64_pkg::t_out_item  w_res;
    logic                 w_set_pend;
    logic                 w_clr_pend;
    rv64_pkg::t_rf_wr     w_wr;

    // execute stage moves when the output register is free or draining
    assign w_ex_go  = r_ex_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_ex_valid || w_ex_go;
    assign w_accept = i_in.valid && i_in.ready;

    assign w_wr.en   = w_ex_go && w_res.reg_write[0];
    assign w_wr.addr = w_res.reg_index;
    assign w_wr.data = w_res.reg_value;

    rv64_regfile u_rf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_en(w_accept),
        .i_rs1(i_in.payload.instr[19:15]), .i_rs2(i_in.payload.instr[24:20]),
        .i_wr(w_wr), .o_a(w_a), .o_b(w_b)
    );

    rv64_alu u_alu (
        .i_item(r_ex_item), .i_pc(r_pc), .i_a(w_a), .i_b(w_b),
        .i_ld_pend(r_ld_pend), .i_ld_dest(r_ld_dest), .i_ld_type(r_ld_type),
        .o_res(w_res), .o_set_pend(w_set_pend), .o_clr_pend(w_clr_pend)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= rv64_pkg::START_ADDRESS;
            r_ld_pend   <= 1'b0;
            r_ld_dest   <= '0;
            r_ld_type   <= '0;
        end else begin
            if (w_accept)     r_ex_valid <= 1'b1;
            else if (w_ex_go) r_ex_valid <= 1'b0;
            if (w_ex_go)                r_out_valid <= 1'b1;
            else if (o_out.ready)       r_out_valid <= 1'b0;
            if (w_ex_go) begin
                r_pc <= w_res.next_pc;
                if (w_set_pend) begin
                    r_ld_pend <= 1'b1;
                    r_ld_dest <= r_ex_item.instr[11:7];
                    r_ld_type <= r_ex_item.instr[14:12];
                end else if (w_clr_pend) begin
                    r_ld_pend <= 1'b0;
                end
            end
        end
        if (w_accept) r_ex_item <= i_in.payload;
        if (w_ex_go)  r_out     <= w_res;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("result dropped");
    a_ex_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex_valid && !w_ex_go |=> r_ex_valid && $stable(r_ex_item))
        else $error("execute item lost");
    a_pc_on_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ex_go |=> $stable(r_pc))
        else $error("pc moved without execute");
    a_reply_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ex_go && w_clr_pend |=> !r_ld_pend)
        else $error("pending load not cleared");
endmodule

>>> rtl/core/rv64_ram.sv
// Generic single-write, registered-read RAM.
module rv64_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/rv64_regfile.sv
// Register file: two RAM read ports, valid bits for reset value, write forwarding.
module rv64_regfile (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [4:0]           i_rs1,
    input  logic [4:0]           i_rs2,
    input  rv64_pkg::t_rf_wr     i_wr,
    output logic [63:0]          o_a,
    output logic [63:0]          o_b
);
    logic [31:0] r_valid;
    logic [4:0]  r_rs1;
    logic [4:0]  r_rs2;
    logic [63:0] w_ra;
    logic [63:0] w_rb;
    logic        r_fwd_a;
    logic        r_fwd_b;
    logic [63:0] r_fwd_data;
    logic [4:0]  w_rs1_eff;
    logic [4:0]  w_rs2_eff;

    // when not reading, keep the last address so the outputs hold
    assign w_rs1_eff = i_rd_en ? i_rs1 : r_rs1;
    assign w_rs2_eff = i_rd_en ? i_rs2 : r_rs2;

    rv64_ram #(.WIDTH(64), .DEPTH(rv64_pkg::REG_COUNT)) u_ram_a (
        .i_clk(i_clk), .i_we(i_wr.en), .i_waddr(i_wr.addr), .i_wdata(i_wr.data),
        .i_raddr(w_rs1_eff), .o_rdata(w_ra)
    );
    rv64_ram #(.WIDTH(64), .DEPTH(rv64_pkg::REG_COUNT)) u_ram_b (
        .i_clk(i_clk), .i_we(i_wr.en), .i_waddr(i_wr.addr), .i_wdata(i_wr.data),
        .i_raddr(w_rs2_eff), .o_rdata(w_rb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rs1   <= '0;
            r_rs2   <= '0;
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rs1   <= w_rs1_eff;
            r_rs2   <= w_rs2_eff;
            r_fwd_a <= i_wr.en && (i_wr.addr == w_rs1_eff);
            r_fwd_b <= i_wr.en && (i_wr.addr == w_rs2_eff);
        end
        r_fwd_data <= i_wr.data;
    end

    // x0 and unwritten entries read their reset values
    always_comb begin
        if (r_rs1 == 5'd0)       o_a = '0;
        else if (r_fwd_a)        o_a = r_fwd_data;
        else if (r_valid[r_rs1]) o_a = w_ra;
        else if (r_rs1 == 5'd2)  o_a = rv64_pkg::STACK_TOP;
        else                     o_a = '0;
        if (r_rs2 == 5'd0)       o_b = '0;
        else if (r_fwd_b)        o_b = r_fwd_data;
        else if (r_valid[r_rs2]) o_b = w_rb;
        else if (r_rs2 == 5'd2)  o_b = rv64_pkg::STACK_TOP;
        else                     o_b = '0;
    end

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.en && i_wr.addr == 5'd0))
        else $error("write to x0");
endmodule

>>> rtl/core/rv64_alu.sv
// Execute logic: decodes one instruction or load reply and forms the result.
module rv64_alu (
    input  rv64_pkg::t_in_item   i_item,
    input  logic [63:0]          i_pc,
    input  logic [63:0]          i_a,
    input  logic [63:0]          i_b,
    input  logic                 i_ld_pend,
    input  logic [4:0]           i_ld_dest,
    input  logic [2:0]           i_ld_type,
    output rv64_pkg::t_out_item  o_res,
    output logic                 o_set_pend,
    output logic                 o_clr_pend
);
    logic [31:0] w_ins;
    logic [6:0]  w_opc;
    logic [6:0]  w_f7;
    logic [2:0]  w_f3;
    logic [4:0]  w_rd;
    logic [63:0] w_immi;
    logic [63:0] w_imms;
    logic [63:0] w_immb;
    logic [63:0] w_immj;
    logic [63:0] w_immu;
    logic [5:0]  w_sh6;
    logic [4:0]  w_sh5;
    logic [63:0] w_src2;
    logic [63:0] w_sum;
    logic [63:0] w_diff;
    logic [31:0] w_a32;
    logic [63:0] w_pc4;
    logic        w_ill;
    logic        w_wr;
    logic        w_take;
    logic [63:0] w_val;
    logic [63:0] w_npc;
    logic [2:0]  w_kind;
    logic [63:0] w_d;

    always_comb begin
        w_ins  = i_item.instr;
        w_opc  = w_ins[6:0];
        w_f3   = w_ins[14:12];
        w_f7   = w_ins[31:25];
        w_rd   = w_ins[11:7];
        w_immi = {{52{w_ins[31]}}, w_ins[31:20]};
        w_imms = {{52{w_ins[31]}}, w_ins[31:25], w_ins[11:7]};
        w_immb = {{51{w_ins[31]}}, w_ins[31], w_ins[7], w_ins[30:25], w_ins[11:8], 1'b0};
        w_immj = {{43{w_ins[31]}}, w_ins[31], w_ins[19:12], w_ins[20], w_ins[30:21], 1'b0};
        w_immu = rv64_pkg::sext32({w_ins[31:12], 12'd0});
        w_pc4  = i_pc + 64'd4;
        w_a32  = i_a[31:0];
        w_src2 = (w_opc == rv64_pkg::OPC_OP || w_opc == rv64_pkg::OPC_OP32) ? i_b : w_immi;
        w_sh6  = w_src2[5:0];
        w_sh5  = w_src2[4:0];
        w_sum  = i_a + w_src2;
        w_diff = i_a - i_b;
        w_ill  = 1'b0;
        w_wr   = 1'b0;
        w_take = 1'b0;
        w_val  = '0;
        w_npc  = w_pc4;
        w_kind = rv64_pkg::KIND_RETIRED;
        w_d    = i_item.load_data;
        o_res  = '0;
        o_set_pend = 1'b0;
        o_clr_pend = 1'b0;

        if (i_item.op == rv64_pkg::OP_REPLY) begin
            w_npc = i_pc;
            if (!i_ld_pend) begin
                w_kind = rv64_pkg::KIND_UNEXP;
            end else begin
                case (i_ld_type)
                    rv64_pkg::LT_LB:  w_val = {{56{w_d[7]}}, w_d[7:0]};
                    rv64_pkg::LT_LH:  w_val = {{48{w_d[15]}}, w_d[15:0]};
                    rv64_pkg::LT_LW:  w_val = rv64_pkg::sext32(w_d[31:0]);
                    rv64_pkg::LT_LBU: w_val = {56'd0, w_d[7:0]};
                    rv64_pkg::LT_LHU: w_val = {48'd0, w_d[15:0]};
                    rv64_pkg::LT_LWU: w_val = {32'd0, w_d[31:0]};
                    default:          w_val = w_d;
                endcase
                w_rd = i_ld_dest;
                w_wr = 1'b1;
                o_clr_pend = 1'b1;
            end
        end else begin
            case (w_opc)
                rv64_pkg::OPC_LOAD: begin
                    if (w_f3 == 3'd7) w_ill = 1'b1;
                    else begin
                        w_kind = rv64_pkg::KIND_LOAD;
                        o_res.mem_addr = w_sum;
                        o_res.mem_size_log2 = w_f3[1:0];
                    end
                end
                rv64_pkg::OPC_STORE: begin
                    if (w_f3[2]) w_ill = 1'b1;
                    else begin
                        w_kind = rv64_pkg::KIND_STORE;
                        o_res.mem_addr = i_a + w_imms;
                        o_res.mem_size_log2 = w_f3[1:0];
                        case (w_f3[1:0])
                            2'd0:    o_res.store_data = {56'd0, i_b[7:0]};
                            2'd1:    o_res.store_data = {48'd0, i_b[15:0]};
                            2'd2:    o_res.store_data = {32'd0, i_b[31:0]};
                            default: o_res.store_data = i_b;
                        endcase
                    end
                end
                rv64_pkg::OPC_OPIMM, rv64_pkg::OPC_OP: begin
                    w_wr = 1'b1;
                    if (w_opc == rv64_pkg::OPC_OPIMM && w_f3 == 3'd1 && w_ins[31:26] != 6'd0)
                        w_ill = 1'b1;
                    else if (w_opc == rv64_pkg::OPC_OPIMM && w_f3 == 3'd5 &&
                             w_ins[31:26] != 6'd0 && w_ins[31:26] != 6'h10)
                        w_ill = 1'b1;
                    else if (w_opc == rv64_pkg::OPC_OP && w_f7 != rv64_pkg::F7_ZERO &&
                             !(w_f7 == rv64_pkg::F7_ALT && (w_f3 == 3'd0 || w_f3 == 3'd5)))
                        w_ill = 1'b1;
                    case (w_f3)
                        3'd0: w_val = (w_opc == rv64_pkg::OPC_OP && w_f7 == rv64_pkg::F7_ALT)
                                      ? w_diff : w_sum;
                        3'd1: w_val = i_a << w_sh6;
                        3'd2: w_val = {63'd0, $signed(i_a) < $signed(w_src2)};
                        3'd3: w_val = {63'd0, i_a < w_src2};
                        3'd4: w_val = i_a ^ w_src2;
                        3'd5: w_val = w_ins[30] ? 64'($signed(i_a) >>> w_sh6) : i_a >> w_sh6;
                        3'd6: w_val = i_a | w_src2;
                        default: w_val = i_a & w_src2;
                    endcase
                end
                rv64_pkg::OPC_OPIMM32, rv64_pkg::OPC_OP32: begin
                    w_wr = 1'b1;
                    if (w_f3 == 3'd0 && w_opc == rv64_pkg::OPC_OPIMM32)
                        w_val = rv64_pkg::sext32(w_sum[31:0]);
                    else if (w_f3 == 3'd0 && w_f7 == rv64_pkg::F7_ZERO)
                        w_val = rv64_pkg::sext32(w_sum[31:0]);
                    else if (w_f3 == 3'd0 && w_f7 == rv64_pkg::F7_ALT)
                        w_val = rv64_pkg::sext32(w_diff[31:0]);
                    else if (w_f3 == 3'd1 && w_f7 == rv64_pkg::F7_ZERO)
                        w_val = rv64_pkg::sext32(w_a32 << w_sh5);
                    else if (w_f3 == 3'd5 && w_f7 == rv64_pkg::F7_ZERO)
                        w_val = rv64_pkg::sext32(w_a32 >> w_sh5);
                    else if (w_f3 == 3'd5 && w_f7 == rv64_pkg::F7_ALT)
                        w_val = rv64_pkg::sext32(32'($signed(w_a32) >>> w_sh5));
                    else w_ill = 1'b1;
                end
                rv64_pkg::OPC_LUI: begin
                    w_wr = 1'b1;
                    w_val = w_immu;
                end
                rv64_pkg::OPC_AUIPC: begin
                    w_wr = 1'b1;
                    w_val = i_pc + w_immu;
                end
                rv64_pkg::OPC_BRANCH: begin
                    case (w_f3)
                        3'd0: w_take = (i_a == i_b);
                        3'd1: w_take = (i_a != i_b);
                        3'd4: w_take = $signed(i_a) < $signed(i_b);
                        3'd5: w_take = $signed(i_a) >= $signed(i_b);
                        3'd6: w_take = i_a < i_b;
                        3'd7: w_take = i_a >= i_b;
                        default: w_ill = 1'b1;
                    endcase
                    if (w_take) w_npc = i_pc + w_immb;
                end
                rv64_pkg::OPC_JALR: begin
                    if (w_f3 != 3'd0) w_ill = 1'b1;
                    w_wr = 1'b1;
                    w_val = w_pc4;
                    w_npc = {w_sum[63:1], 1'b0};
                end
                rv64_pkg::OPC_JAL: begin
                    w_wr = 1'b1;
                    w_val = w_pc4;
                    w_npc = i_pc + w_immj;
                end
                default: w_ill = 1'b1;
            endcase
            if (w_ill) begin
                w_kind = rv64_pkg::KIND_ILLEGAL;
                w_npc = i_pc;
                o_res.mem_addr = '0;
                o_res.mem_size_log2 = '0;
                o_res.store_data = '0;
                w_wr = 1'b0;
            end else if (w_kind == rv64_pkg::KIND_LOAD) begin
                o_set_pend = 1'b1;
            end
        end

        o_res.kind    = w_kind;
        o_res.next_pc = w_npc;
        if (w_wr && w_rd != 5'd0) begin
            o_res.reg_write = 1'b1;
            o_res.reg_index = w_rd;
            o_res.reg_value = w_val;
        end
    end
endmodule

>>> verif/tb_rv64i_execute_unit.sv
// Testbench: directed and random RV64I instruction and load-reply traffic, checked by a predictor.
module tb_rv64i_execute_unit;
    import rv64_pkg::*;

    localparam int N_RANDOM   = 1450;
    localparam int MAX_CYCLES = 400000;

    logic i_clk;
    logic i_rst_n;

    rv64_in_if  in_ch ();
    rv64_out_if out_ch ();

    rv64i_execute_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state: architectural registers, pc and the pending-load record.
    logic [63:0] arch_regs [32];
    logic [63:0] arch_pc;
    logic        ld_pending;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_type;

    t_out_item expected_results [$];
    int        n_errors;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_off;

    function automatic logic [63:0] sext(input logic [63:0] v, input int bits);
        logic [63:0] m;
        m = 64'd1 << (bits - 1);
        v = v & ((m << 1) - 64'd1);
        return (v ^ m) - m;
    endfunction

    task automatic predictor_reset();
        for (int i = 0; i < 32; i++) arch_regs[i] = '0;
        arch_regs[2] = STACK_TOP;
        arch_pc    = START_ADDRESS;
        ld_pending = 1'b0;
        ld_dest    = '0;
        ld_type    = '0;
    endtask

    // Executes one transaction on the predictor and returns the expected result.
    function automatic t_out_item execute_item(input t_in_item it);
        t_out_item   r;
        logic [31:0] ins;
        logic [6:0]  opc, f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [63:0] a, b, imm_i, imm_b, imm_j, val, npc;
        logic [5:0]  sh6;
        logic [4:0]  sh5;
        bit          ill, wr, taken;
        r     = '0;
        ins   = it.instr;
        opc   = ins[6:0];
        rd    = ins[11:7];
        f3    = ins[14:12];
        f7    = ins[31:25];
        a     = arch_regs[ins[19:15]];
        b     = arch_regs[ins[24:20]];
        imm_i = sext({52'd0, ins[31:20]}, 12);
        imm_b = sext({51'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
        imm_j = sext({43'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
        sh6   = ins[25:20];
        sh5   = ins[24:20];
        ill   = 0;
        wr    = 0;
        val   = '0;
        npc   = arch_pc + 64'd4;
        r.kind = KIND_RETIRED;
        if (it.op == OP_REPLY) begin
            npc = arch_pc;
            if (!ld_pending) begin
                r.kind = KIND_UNEXP;
            end else begin
                case (ld_type)
                    LT_LB:   val = sext(it.load_data, 8);
                    LT_LH:   val = sext(it.load_data, 16);
                    LT_LW:   val = sext(it.load_data, 32);
                    LT_LBU:  val = {56'd0, it.load_data[7:0]};
                    LT_LHU:  val = {48'd0, it.load_data[15:0]};
                    LT_LWU:  val = {32'd0, it.load_data[31:0]};
                    default: val = it.load_data;
                endcase
                rd = ld_dest;
                wr = 1;
                ld_pending = 1'b0;
            end
        end else begin
            case (opc)
                OPC_LOAD: begin
                    if (f3 == 3'd7) ill = 1;
                    else begin
                        r.kind = KIND_LOAD;
                        r.mem_addr = a + imm_i;
                        r.mem_size_log2 = f3[1:0];
                    end
                end
                OPC_STORE: begin
                    if (f3 > 3'd3) ill = 1;
                    else begin
                        r.kind = KIND_STORE;
                        r.mem_size_log2 = f3[1:0];
                        r.mem_addr = a + sext({52'd0, ins[31:25], ins[11:7]}, 12);
                        r.store_data = (f3 == 3'd3) ? b
                                     : (b & ((64'd1 << (8 << f3)) - 64'd1));
                    end
                end
                OPC_OPIMM: begin
                    wr = 1;
                    case (f3)
                        3'd0: val = a + imm_i;
                        3'd1: if (ins[31:26] != 0) ill = 1; else val = a << sh6;
                        3'd2: val = {63'd0, $signed(a) < $signed(imm_i)};
                        3'd3: val = {63'd0, a < imm_i};
                        3'd4: val = a ^ imm_i;
                        3'd5: begin
                            if (ins[31:26] == 6'h00) val = a >> sh6;
                            else if (ins[31:26] == 6'h10) val = $signed(a) >>> sh6;
                            else ill = 1;
                        end
                        3'd6: val = a | imm_i;
                        default: val = a & imm_i;
                    endcase
                end
                OPC_OPIMM32: begin
                    wr = 1;
                    if (f3 == 3'd0) val = sext(a + imm_i, 32);
                    else if (f3 == 3'd1 && f7 == F7_ZERO) val = sext(a << sh5, 32);
                    else if (f3 == 3'd5 && f7 == F7_ZERO) val = sext({32'd0, a[31:0]} >> sh5, 32);
                    else if (f3 == 3'd5 && f7 == F7_ALT)
                        val = sext($signed(sext(a, 32)) >>> sh5, 32);
                    else ill = 1;
                end
                OPC_OP: begin
                    wr = 1;
                    if (f3 == 3'd0 && f7 == F7_ZERO) val = a + b;
                    else if (f3 == 3'd0 && f7 == F7_ALT) val = a - b;
                    else if (f3 == 3'd5 && f7 == F7_ALT) val = $signed(a) >>> b[5:0];
                    else if (f7 != F7_ZERO) ill = 1;
                    else case (f3)
                        3'd1: val = a << b[5:0];
                        3'd2: val = {63'd0, $signed(a) < $signed(b)};
                        3'd3: val = {63'd0, a < b};
                        3'd4: val = a ^ b;
                        3'd5: val = a >> b[5:0];
                        3'd6: val = a | b;
                        default: val = a & b;
                    endcase
                end
                OPC_OP32: begin
                    wr = 1;
                    if (f3 == 3'd0 && f7 == F7_ZERO) val = sext(a + b, 32);
                    else if (f3 == 3'd0 && f7 == F7_ALT) val = sext(a - b, 32);
                    else if (f3 == 3'd1 && f7 == F7_ZERO) val = sext(a << b[4:0], 32);
                    else if (f3 == 3'd5 && f7 == F7_ZERO)
                        val = sext({32'd0, a[31:0]} >> b[4:0], 32);
                    else if (f3 == 3'd5 && f7 == F7_ALT)
                        val = sext($signed(sext(a, 32)) >>> b[4:0], 32);
                    else ill = 1;
                end
                OPC_LUI: begin
                    wr = 1;
                    val = sext({32'd0, ins[31:12], 12'd0}, 32);
                end
                OPC_AUIPC: begin
                    wr = 1;
                    val = arch_pc + sext({32'd0, ins[31:12], 12'd0}, 32);
                end
                OPC_BRANCH: begin
                    taken = 0;
                    case (f3)
                        3'd0: taken = (a == b);
                        3'd1: taken = (a != b);
                        3'd4: taken = $signed(a) < $signed(b);
                        3'd5: taken = $signed(a) >= $signed(b);
                        3'd6: taken = a < b;
                        3'd7: taken = a >= b;
                        default: ill = 1;
                    endcase
                    if (taken) npc = arch_pc + imm_b;
                end
                OPC_JALR: begin
                    if (f3 != 3'd0) ill = 1;
                    else begin
                        wr  = 1;
                        val = arch_pc + 64'd4;
                        npc = (a + imm_i) & ~64'd1;
                    end
                end
                OPC_JAL: begin
                    wr  = 1;
                    val = arch_pc + 64'd4;
                    npc = arch_pc + imm_j;
                end
                default: ill = 1;
            endcase
            if (ill) begin
                r   = '0;
                r.kind = KIND_ILLEGAL;
                npc = arch_pc;
                wr  = 0;
            end else begin
                arch_pc = npc;
                if (r.kind == KIND_LOAD) begin
                    ld_pending = 1'b1;
                    ld_dest    = rd;
                    ld_type    = f3;
                end
            end
        end
        if (wr && rd != 0) begin
            arch_regs[rd] = val;
            r.reg_write = 1'b1;
            r.reg_index = rd;
            r.reg_value = val;
        end
        r.next_pc = npc;
        return r;
    endfunction

    // Directed stimulus; typed-in results are used where has_exp is set.
    typedef struct {
        t_in_item  item;
        bit        has_exp;
        t_out_item exp;
    } t_directed_row;

    t_directed_row directed_rows [$];

    function automatic t_in_item exec_word(input logic [31:0] w);
        t_in_item it;
        it.op = OP_EXEC;
        it.instr = w;
        it.load_data = {32'd0, $urandom()};
        return it;
    endfunction

    function automatic t_in_item reply_word(input logic [63:0] d);
        t_in_item it;
        it.op = OP_REPLY;
        it.instr = $urandom();
        it.load_data = d;
        return it;
    endfunction

    function automatic logic [31:0] r_type(input logic [6:0] opc, input logic [2:0] f3,
                                           input logic [6:0] f7, input logic [4:0] rd,
                                           input logic [4:0] rs1, input logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] i_type(input logic [6:0] opc, input logic [2:0] f3,
                                           input logic [4:0] rd, input logic [4:0] rs1,
                                           input logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] s_type(input logic [6:0] opc, input logic [2:0] f3,
                                           input logic [4:0] rs1, input logic [4:0] rs2,
                                           input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
    endfunction

    task automatic add_row(input t_in_item it, input bit has_exp, input t_out_item e);
        t_directed_row row;
        row.item = it;
        row.has_exp = has_exp;
        row.exp = e;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed();
        t_out_item e;
        // reply right after reset: nothing pending
        e = '0; e.kind = KIND_UNEXP; e.next_pc = START_ADDRESS;
        add_row(reply_word(64'hFFFF_FFFF_FFFF_FFFF), 1, e);
        // all-zero word is an illegal opcode
        e = '0; e.kind = KIND_ILLEGAL; e.next_pc = START_ADDRESS;
        add_row(exec_word(32'h0000_0000), 1, e);
        e = '0; e.kind = KIND_ILLEGAL; e.next_pc = START_ADDRESS;
        add_row(exec_word(32'hFFFF_FFFF), 1, e);
        // addi x5, x2, -1: stack top minus one
        e = '0; e.next_pc = START_ADDRESS + 64'd4; e.reg_write = 1'b1; e.reg_index = 5'd5;
        e.reg_value = STACK_TOP - 64'd1;
        add_row(exec_word(i_type(OPC_OPIMM, 3'd0, 5'd5, 5'd2, 12'hFFF)), 1, e);
        add_row(exec_word(i_type(OPC_OPIMM, 3'd0, 5'd0, 5'd2, 12'h7FF)), 0, '0);
        add_row(exec_word(32'h8000_0037 | (32'd6 << 7)), 0, '0);              // lui x6
        add_row(exec_word(32'hFFFF_F017 | (32'd7 << 7)), 0, '0);              // auipc x7
        add_row(exec_word(i_type(OPC_OPIMM, 3'd3, 5'd8, 5'd6, 12'hFFF)), 0, '0);  // sltiu
        add_row(exec_word(i_type(OPC_OPIMM, 3'd5, 5'd9, 5'd6, 12'h43F)), 0, '0);  // srai 63
        add_row(exec_word(i_type(OPC_OPIMM, 3'd1, 5'd9, 5'd6, 12'h040)), 0, '0);  // bad slli
        add_row(exec_word(i_type(OPC_OPIMM32, 3'd5, 5'd10, 5'd6, 12'h41F)), 0, '0); // sraiw
        add_row(exec_word(i_type(OPC_OPIMM32, 3'd5, 5'd10, 5'd6, 12'h01F)), 0, '0); // srliw
        add_row(exec_word(r_type(OPC_OP, 3'd0, F7_ALT, 5'd11, 5'd0, 5'd2)), 0, '0);
        add_row(exec_word(r_type(OPC_OP, 3'd1, F7_ZERO, 5'd12, 5'd6, 5'd11)), 0, '0);
        add_row(exec_word(r_type(OPC_OP32, 3'd5, F7_ALT, 5'd13, 5'd6, 5'd11)), 0, '0);
        add_row(exec_word(s_type(OPC_STORE, 3'd3, 5'd2, 5'd11, 12'h800)), 0, '0);
        add_row(exec_word(s_type(OPC_STORE, 3'd0, 5'd2, 5'd11, 12'h7FF)), 0, '0);
        add_row(exec_word(i_type(OPC_LOAD, 3'd0, 5'd14, 5'd2, 12'h000)), 0, '0);  // lb
        add_row(exec_word(r_type(OPC_OP, 3'd4, F7_ZERO, 5'd14, 5'd6, 5'd7)), 0, '0);
        add_row(reply_word(64'h0000_0000_0000_0080), 0, '0);
        add_row(exec_word(i_type(OPC_LOAD, 3'd6, 5'd0, 5'd2, 12'h001)), 0, '0);   // lwu x0
        add_row(reply_word(64'hFFFF_FFFF_FFFF_FFFF), 0, '0);
        add_row(exec_word(32'hFFF0_00EF), 0, '0);                           // jal x1, neg
        add_row(exec_word(i_type(OPC_JALR, 3'd0, 5'd1, 5'd7, 12'h001)), 0, '0);
        add_row(exec_word(32'h80E3_1063 | (32'd1 << 12)), 0, '0);              // bne back
        add_row(exec_word(32'h0FF0_000F), 0, '0);                           // fence
    endtask

    // Random instruction words biased toward legal encodings.
    function automatic t_in_item random_item();
        logic [6:0] opcs [11];
        logic [31:0] w;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        int          pick;
        opcs = '{OPC_LOAD, OPC_OPIMM, OPC_AUIPC, OPC_OPIMM32, OPC_STORE, OPC_OP,
                 OPC_LUI, OPC_OP32, OPC_BRANCH, OPC_JALR, OPC_JAL};
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return reply_word({$urandom(), $urandom()});
        w   = $urandom();
        if (pick < 17) return exec_word(w);
        rd  = w[11:7];
        rs1 = 5'($urandom_range(0, 15));
        rs2 = 5'($urandom_range(0, 15));
        f3  = w[14:12];
        w[6:0] = opcs[$urandom_range(0, 10)];
        w[19:15] = rs1;
        w[24:20] = rs2;
        if (w[6:0] == OPC_OP || w[6:0] == OPC_OP32 || $urandom_range(0, 3) == 0)
            w[31:25] = ($urandom_range(0, 9) == 0) ? w[31:25]
                     : ($urandom_range(0, 1) ? F7_ALT : F7_ZERO);
        if (w[6:0] == OPC_OPIMM && (f3 == 3'd1 || f3 == 3'd5) && $urandom_range(0, 7) != 0)
            w[31:26] = $urandom_range(0, 1) ? 6'h10 : 6'h00;
        if (w[6:0] == OPC_JALR && $urandom_range(0, 7) != 0) w[14:12] = 3'd0;
        return exec_word(w);
    endfunction

    // Source side: drives one transaction and predicts it when accepted.
    // Typed-in rows check the block against the typed value; the predictor
    // still runs so its state follows the block.
    task automatic send_item(input t_in_item it, input bit has_exp, input t_out_item e);
        t_out_item r;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        r = execute_item(it);
        if (has_exp) expected_results.push_back(e);
        else         expected_results.push_back(r);
    endtask

    // Sink side: random stalls plus a long hold-off window.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= !hold_off &&
                            !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %h", got);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind) begin
                    $error("kind exp %0d got %0d", want.kind, got.kind); n_errors++;
                end
                if (got.next_pc !== want.next_pc) begin
                    $error("next_pc exp %h got %h", want.next_pc, got.next_pc); n_errors++;
                end
                if (got.mem_addr !== want.mem_addr) begin
                    $error("mem_addr exp %h got %h", want.mem_addr, got.mem_addr); n_errors++;
                end
                if (got.mem_size_log2 !== want.mem_size_log2) begin
                    $error("mem_size_log2 exp %0d got %0d", want.mem_size_log2,
                           got.mem_size_log2); n_errors++;
                end
                if (got.store_data !== want.store_data) begin
                    $error("store_data exp %h got %h", want.store_data, got.store_data);
                    n_errors++;
                end
                if (got.reg_write !== want.reg_write) begin
                    $error("reg_write exp %0d got %0d", want.reg_write, got.reg_write);
                    n_errors++;
                end
                if (got.reg_index !== want.reg_index) begin
                    $error("reg_index exp %0d got %0d", want.reg_index, got.reg_index);
                    n_errors++;
                end
                if (got.reg_value !== want.reg_value) begin
                    $error("reg_value exp %h got %h", want.reg_value, got.reg_value);
                    n_errors++;
                end
            end
        end
    end

    // Run timeout.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLES) begin
                $display("rv64i_execute_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        int i;
        n_errors       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 0;
        in_ch.valid    <= 1'b0;
        in_ch.payload  <= '0;
        i_rst_n        <= 1'b0;
        predictor_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed();
        foreach (directed_rows[k])
            send_item(directed_rows[k].item, directed_rows[k].has_exp, directed_rows[k].exp);

        // Long receiver hold-off while the source keeps pushing.
        fork
            begin
                hold_off = 1;
                repeat (60) @(posedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < 20; k++) send_item(random_item(), 0, '0);
        join

        for (i = 0; i < N_RANDOM; i++) begin
            case ((i * 5) / N_RANDOM)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                3: begin send_idle_pct = 22; recv_stall_pct = 22; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            send_item(random_item(), 0, '0);
        end
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("rv64i_execute_unit verification clean");
        else
            $display("rv64i_execute_unit verification failed");
        $finish;
    end
endmodule
